// ===== hdl/modexp_pkg.sv =====
// Shared constants and types for the modular exponentiation core.
package modexp_pkg;

    localparam int unsigned OPERAND_WIDTH = 32;
    localparam int unsigned FIELD_WIDTH   = 32;
    localparam int unsigned IN_TDATA_W    = 2 * FIELD_WIDTH;
    localparam int unsigned OUT_TDATA_W   = FIELD_WIDTH;
    localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'd533;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_DONE
    } t_state;

endpackage

// ===== hdl/modexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: each bit of a takes a doubling phase and an add phase.
module modexp_mulmod #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_r
);
    import modexp_pkg::*;

    localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_m;
    logic [W-1:0]     r_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_phase;
    logic             r_busy;
    logic             r_done;

    logic [W:0]       w_sum;
    logic [W+1:0]     w_diff;
    logic [W-1:0]     w_red;
    logic             w_last;

    // Phase 0 doubles the partial result, phase 1 adds b when the a bit is set.
    always_comb begin
        if (!r_phase) begin
            w_sum = {r_r, 1'b0};
        end else if (r_a[W-1]) begin
            w_sum = {1'b0, r_r} + {1'b0, r_b};
        end else begin
            w_sum = {1'b0, r_r};
        end
        w_diff = {1'b0, w_sum} - {2'b00, r_m};
        w_red  = w_diff[W+1] ? w_sum[W-1:0] : w_diff[W-1:0];
    end

    assign w_last = r_phase && (r_cnt == CNT_W'(W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= w_red;
            if (r_phase) begin
                r_a <= {r_a[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

// ===== hdl/modular_exponentiation_core.sv =====
// Right-to-left binary modular exponentiation, base ** exponent mod modulus.
// A zero exponent goes straight to the done state with a result of 1; otherwise the squarer
// first reduces the base mod modulus, then one step runs per exponent bit up to the top set bit.
// Each step is one bit-serial modular multiply (a doubling and an add phase per bit); square and
// multiply run side by side. One item in flight: new operands are taken only in the idle state.
// Synchronous active-low reset clears control state and loads the modulus with 533.
module modular_exponentiation_core #(
    parameter int unsigned OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] base_value, [63:32] exponent
    input  logic [modexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] power_result
    output logic [modexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import modexp_pkg::*;

    localparam int unsigned W = OPERAND_WIDTH;
    localparam logic [W-1:0] MOD_RST_RAW = MODULUS_RESET[W-1:0];
    localparam logic [W-1:0] MOD_RST = (MOD_RST_RAW == '0) ? W'(1) : MOD_RST_RAW;
    localparam logic [W-1:0] ONE = W'(1);

    t_state r_state;
    t_state n_state;

    logic [W-1:0]           r_mod;
    logic [W-1:0]           r_base;
    logic [W-1:0]           r_exp;
    logic [W-1:0]           r_acc;
    logic                   r_go;
    logic                   r_ovld;
    logic [OUT_TDATA_W-1:0] r_odata;

    logic [W-1:0] w_base_in;
    logic [W-1:0] w_exp_in;
    logic         w_accept;
    logic         w_out_free;
    logic         w_load_out;
    logic         w_more;
    logic         w_sq_start;
    logic         w_mul_start;
    logic [W-1:0] w_sq_b;
    logic         w_sq_done;
    logic [W-1:0] w_sq_r;
    logic         w_mul_done;
    logic [W-1:0] w_mul_r;

    assign w_base_in  = s_axis_tdata[W-1:0];
    assign w_exp_in   = s_axis_tdata[FIELD_WIDTH +: W];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovld || m_axis_tready;
    assign w_more     = (r_exp[W-1:1] != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_exp_in == '0) ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (w_sq_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (w_sq_done && !w_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        w_sq_b        = r_base;
        w_mul_start   = 1'b0;
        unique case (r_state)
            S_IDLE:   s_axis_tready = 1'b1;
            S_REDUCE: w_sq_b = ONE;
            S_STEP:   w_mul_start = r_go && r_exp[0];
            S_DONE:   w_load_out = w_out_free;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_sq_start = r_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= MOD_RST;
            r_go    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            // drop writes of zero
            if (i_cfg_we && (i_cfg_wdata[W-1:0] != '0)) begin
                r_mod <= i_cfg_wdata[W-1:0];
            end
            r_go <= (w_accept && (w_exp_in != '0))
                 || (w_sq_done && (r_state == S_REDUCE))
                 || (w_sq_done && (r_state == S_STEP) && w_more);
            if (w_load_out) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= w_base_in;
            r_exp  <= w_exp_in;
            if (w_exp_in == '0) begin
                r_acc <= ONE;
            end else begin
                r_acc <= (r_mod == ONE) ? '0 : ONE;
            end
        end else if (w_sq_done && (r_state == S_REDUCE)) begin
            r_base <= w_sq_r;
        end else if (w_sq_done && (r_state == S_STEP)) begin
            r_base <= w_sq_r;
            r_exp  <= {1'b0, r_exp[W-1:1]};
            if (r_exp[0]) begin
                r_acc <= w_mul_r;
            end
        end
        if (w_load_out) begin
            r_odata <= OUT_TDATA_W'(r_acc);
        end
    end

    // Squarer also performs the initial base reduction (base * 1 mod m)
    modexp_mulmod #(
        .W (W)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_a     (r_base),
        .i_b     (w_sq_b),
        .i_m     (r_mod),
        .o_done  (w_sq_done),
        .o_r     (w_sq_r)
    );

    modexp_mulmod #(
        .W (W)
    ) u_multiply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_base),
        .i_b     (r_acc),
        .i_m     (r_mod),
        .o_done  (w_mul_done),
        .o_r     (w_mul_r)
    );

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod != '0)
        else $error("modulus register holds zero");

    a_sq_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_REDUCE || r_state == S_STEP))
        else $error("squarer finished outside a compute state");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_STEP && r_exp[0] && w_sq_done))
        else $error("multiplier finished out of step with squarer");

    a_sq_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (w_sq_r < r_mod))
        else $error("squarer result not reduced");

endmodule

// ===== tb/sv/modexp_checker.sv =====
// Checker for the modular exponentiation core: predicts each power and compares result beats.
module modexp_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] i_cfg_wdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    // [31:0] base_value, [63:32] exponent
    input  logic [modexp_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    // [31:0] power_result
    input  logic [modexp_pkg::OUT_TDATA_W-1:0] i_out_data,
    output int                                 o_pending,
    output int                                 o_errors
);
    import modexp_pkg::*;

    localparam logic [63:0] OPERAND_MASK = (64'd1 << OPERAND_WIDTH) - 64'd1;

    logic [FIELD_WIDTH-1:0] modulus_copy = MODULUS_RESET;
    logic [FIELD_WIDTH-1:0] expected_powers[$];
    int                     error_count = 0;

    assign o_errors = error_count;

    function automatic logic [FIELD_WIDTH-1:0] power_mod(
        input logic [FIELD_WIDTH-1:0] base_in,
        input logic [FIELD_WIDTH-1:0] power_in,
        input logic [FIELD_WIDTH-1:0] modulus_in
    );
        logic [63:0] m;
        logic [63:0] square;
        logic [63:0] acc;
        logic [63:0] power_bits;
        m          = 64'(modulus_in) & OPERAND_MASK;
        power_bits = 64'(power_in) & OPERAND_MASK;
        if (m == 64'd0) begin
            m = 64'd1;
        end
        // zero exponent answers 1 without reduction, even for a modulus of one
        if (power_bits == 64'd0) begin
            return FIELD_WIDTH'(1);
        end
        square = (64'(base_in) & OPERAND_MASK) % m;
        acc    = 64'd1 % m;
        for (int i = 0; i < OPERAND_WIDTH; i++) begin
            if (power_bits[i]) begin
                acc = (acc * square) % m;
            end
            square = (square * square) % m;
        end
        return acc[FIELD_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_WIDTH-1:0] got,
                                   input logic [FIELD_WIDTH-1:0] want);
        $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        logic [63:0]            masked_cfg;
        logic [FIELD_WIDTH-1:0] want;
        if (!i_rst_n) begin
            modulus_copy = MODULUS_RESET;
            expected_powers.delete();
        end else begin
            // drop writes whose kept bits are all zero
            masked_cfg = 64'(i_cfg_wdata) & OPERAND_MASK;
            if (i_cfg_we && masked_cfg != 64'd0) begin
                modulus_copy = masked_cfg[FIELD_WIDTH-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                expected_powers.push_back(power_mod(i_in_data[FIELD_WIDTH-1:0],
                                                    i_in_data[2*FIELD_WIDTH-1:FIELD_WIDTH],
                                                    modulus_copy));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_powers.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    i_out_data[FIELD_WIDTH-1:0], '0);
                end else begin
                    want = expected_powers.pop_front();
                    if (i_out_data[FIELD_WIDTH-1:0] !== want) begin
                        report_mismatch("power_result", i_out_data[FIELD_WIDTH-1:0], want);
                    end
                end
            end
        end
        o_pending <= expected_powers.size();
    end

endmodule

// ===== tb/sv/tb_modular_exponentiation_core.sv =====
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
module tb_modular_exponentiation_core;
    import modexp_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES  = 2200;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 34;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [FIELD_WIDTH-1:0] i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] base_value, [63:32] exponent
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] power_result
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                     pending;
    int                     mismatches;
    int unsigned            cycle_count   = 0;
    int unsigned            send_idle_pct = 19;
    int unsigned            recv_idle_pct = 58;
    logic [FIELD_WIDTH-1:0] cur_modulus   = MODULUS_RESET;

    modular_exponentiation_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    modexp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_pending   (pending),
        .o_errors    (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold tvalid high from one beat to the next unless an idle cycle is drawn.
    task automatic send_operands(input logic [FIELD_WIDTH-1:0] base_value,
                                 input logic [FIELD_WIDTH-1:0] power);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {power, base_value};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_modulus(input logic [FIELD_WIDTH-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (value != '0) begin
            cur_modulus = value;
        end
    endtask

    // Keep most exponents short so the run stays brief; a few span all 32 bits.
    task automatic send_random_item();
        logic [FIELD_WIDTH-1:0] base_value;
        logic [FIELD_WIDTH-1:0] power;
        int unsigned            pick;
        case ($urandom_range(7))
            0:       base_value = '0;
            1:       base_value = cur_modulus - 1;
            2:       base_value = cur_modulus;
            3:       base_value = '1;
            4:       base_value = $urandom_range(15);
            default: base_value = $urandom();
        endcase
        pick = $urandom_range(15);
        if (pick == 0) begin
            power = '0;
        end else if (pick <= 2) begin
            power = $urandom();
        end else begin
            power = $urandom() & ((32'd1 << $urandom_range(1, 10)) - 32'd1);
        end
        send_operands(base_value, power);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus 533
        send_operands(32'd0, 32'd0);
        send_operands(32'd5, 32'd0);
        send_operands(32'd0, 32'd1);
        send_operands(32'd533, 32'd5);
        send_operands(32'd532, 32'd2);
        send_operands(32'd2, 32'd1);
        send_operands(32'd7, 32'h8000_0000);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'h5555_5555, 32'h5555_5555);
        send_operands(32'hAAAA_AAAA, 32'hAAAA_AAAA);

        // modulus of one: zero exponent still answers 1
        write_modulus(32'd1);
        send_operands(32'd5, 32'd0);
        send_operands(32'd5, 32'd3);
        send_operands(32'd0, 32'd0);

        // zero write is dropped; modulus stays one
        write_modulus(32'd0);
        send_operands(32'd7, 32'd0);
        send_operands(32'd7, 32'd2);

        write_modulus(32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFE, 32'd2);
        send_operands(32'hFFFF_FFFF, 32'd5);
        send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 58;
            end else if (phase < 6) begin
                send_idle_pct = 58;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0:       write_modulus(MODULUS_RESET);
                1:       write_modulus(32'd2);
                2:       write_modulus($urandom_range(3, 1000));
                3:       write_modulus(32'hFFFF_FFFB);
                4:       write_modulus(32'd1);
                5:       write_modulus(32'h8000_0000 | $urandom());
                6:       write_modulus($urandom_range(2, 65535));
                default: write_modulus(32'hFFFF_FFFF);
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
